// File: rtl/core/pjs_pkg.sv
package pjs_pkg;

  localparam int unsigned MaxJobs = 16;
  localparam int unsigned IdxW    = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned CntW    = $clog2(MaxJobs + 1);

  localparam int unsigned IdW    = 8;
  localparam int unsigned ArrW   = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TimeW  = 21;
  localparam int unsigned WaitW  = 20;

  typedef struct packed {
    logic [IdW-1:0]    job_id;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  priority_req;
    logic              last_job;
  } job_t;

  typedef struct packed {
    logic [IdW-1:0]   done_id;
    logic [TimeW-1:0] completion;
    logic [TimeW-1:0] turnaround;
    logic [WaitW-1:0] waiting;
    logic             last_result;
  } res_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic            clr;
    logic            vld;
    logic            fin;
    logic [IdxW-1:0] idx;
  } sel_ctrl_t;

  typedef struct packed {
    logic            have_pick;
    logic [IdxW-1:0] idx;
    entry_t          pick;
    logic            have_next;
    logic [ArrW-1:0] next_arr;
  } sel_res_t;

  typedef enum logic [1:0] {
    StLoad,
    StScan,
    StOut
  } state_e;

endpackage

// File: rtl/core/pjs_intf.sv
interface pjs_job_if;
  import pjs_pkg::*;

  logic valid;
  logic ready;
  job_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pjs_res_if;
  import pjs_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/pjs_table.sv
module pjs_table (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [pjs_pkg::IdxW-1:0]  waddr_i,
  input  pjs_pkg::entry_t           wdata_i,
  input  logic                      re_i,
  input  logic [pjs_pkg::IdxW-1:0]  raddr_i,
  output pjs_pkg::entry_t           rdata_o
);
  import pjs_pkg::*;

  entry_t mem_q [MaxJobs];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pjs_sel.sv
module pjs_sel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pjs_pkg::sel_ctrl_t        ctrl_i,
  input  pjs_pkg::entry_t           entry_i,
  input  logic [pjs_pkg::TimeW-1:0] time_i,
  output pjs_pkg::sel_res_t         res_o
);
  import pjs_pkg::*;

  logic            have_pick_q;
  logic            have_next_q;
  logic [IdxW-1:0] pick_idx_q;
  entry_t          pick_q;
  logic [ArrW-1:0] next_arr_q;

  logic arrived;
  logic take_pick;
  logic take_next;

  // one entry per cycle: best arrived priority, earliest pending arrival
  always_comb begin
    arrived   = TimeW'(entry_i.arrival) <= time_i;
    take_pick = ctrl_i.vld && !ctrl_i.fin && arrived &&
                (!have_pick_q || (entry_i.prio < pick_q.prio));
    take_next = ctrl_i.vld && !ctrl_i.fin && !arrived &&
                (!have_next_q || (entry_i.arrival < next_arr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_pick_q <= 1'b0;
      have_next_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      have_pick_q <= 1'b0;
      have_next_q <= 1'b0;
    end else begin
      if (take_pick) begin
        have_pick_q <= 1'b1;
      end
      if (take_next) begin
        have_next_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pick) begin
      pick_q     <= entry_i;
      pick_idx_q <= ctrl_i.idx;
    end
    if (take_next) begin
      next_arr_q <= entry_i.arrival;
    end
  end

  always_comb begin
    res_o.have_pick = have_pick_q;
    res_o.idx       = pick_idx_q;
    res_o.pick      = pick_q;
    res_o.have_next = have_next_q;
    res_o.next_arr  = next_arr_q;
  end

endmodule

// File: rtl/core/priority_job_scheduler.sv
// Non-preemptive priority scheduler. Jobs load one word per cycle into a
// 16-entry table; the word marked last, or the one that fills the table,
// starts the schedule and the block stops taking words until the final
// result has been taken. Each result costs one scan pass (one read per
// loaded entry through the single read port, the table's registered
// read, a decision step) plus a hand-over on the output port, which may
// stall; every idle gap in arrivals adds one more pass that moves time to
// the next arrival. Ties in priority go to the job loaded first, and the
// table is empty again after the last result.
module priority_job_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  pjs_job_if.sink   job_i,
  pjs_res_if.source res_o
);
  import pjs_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   loaded_q, loaded_d;
  logic [CntW-1:0]   done_q, done_d;
  logic [CntW-1:0]   ridx_q, ridx_d;
  logic [MaxJobs-1:0] mask_q, mask_d;
  logic [TimeW-1:0]  t_q, t_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pidx_q, pidx_d;
  res_t              res_q, res_d;

  logic      in_acc;
  logic      out_acc;
  logic      start;
  logic      scan_end;
  logic      rd_en;
  entry_t    wr_entry;
  entry_t    rd_entry;
  sel_ctrl_t sel_ctrl;
  sel_res_t  sel_res;

  assign in_acc   = job_i.valid & job_i.ready;
  assign out_acc  = res_o.valid & res_o.ready;
  assign start    = in_acc &&
                    (job_i.data.last_job || (loaded_q == CntW'(MaxJobs - 1)));
  assign scan_end = (state_q == StScan) && (ridx_q == loaded_q) && !pend_q;
  assign rd_en    = (state_q == StScan) && (ridx_q != loaded_q);

  assign job_i.ready = (state_q == StLoad);
  assign res_o.valid = (state_q == StOut);
  assign res_o.data  = res_q;

  always_comb begin
    wr_entry.id      = job_i.data.job_id;
    wr_entry.arrival = job_i.data.arrival;
    wr_entry.burst   = job_i.data.burst;
    wr_entry.prio    = job_i.data.priority_req;
  end

  pjs_table u_table (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (loaded_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (ridx_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    sel_ctrl.clr = (state_q == StScan) && (ridx_q == '0);
    sel_ctrl.vld = pend_q;
    sel_ctrl.fin = mask_q[pidx_q];
    sel_ctrl.idx = pidx_q;
  end

  pjs_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sel_ctrl),
    .entry_i (rd_entry),
    .time_i  (t_q),
    .res_o   (sel_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (start) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_end && sel_res.have_pick) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_acc) begin
          state_d = res_q.last_result ? StLoad : StScan;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_comb begin
    logic [TimeW-1:0] comp;
    logic [TimeW-1:0] wt;

    loaded_d = loaded_q;
    done_d   = done_q;
    ridx_d   = ridx_q;
    mask_d   = mask_q;
    t_d      = t_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    res_d    = res_q;
    comp     = t_q + TimeW'(sel_res.pick.burst);
    wt       = t_q - TimeW'(sel_res.pick.arrival);

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          loaded_d = loaded_q + CntW'(1);
        end
        if (start) begin
          ridx_d = '0;
          done_d = '0;
          mask_d = '0;
          t_d    = '0;
        end
      end
      StScan: begin
        pend_d = rd_en;
        pidx_d = ridx_q[IdxW-1:0];
        if (rd_en) begin
          ridx_d = ridx_q + CntW'(1);
        end
        if (scan_end) begin
          ridx_d = '0;
          if (sel_res.have_pick) begin
            res_d.done_id       = sel_res.pick.id;
            res_d.completion    = comp;
            res_d.turnaround    = comp - TimeW'(sel_res.pick.arrival);
            res_d.waiting       = wt[WaitW-1:0];
            res_d.last_result   = (done_q + CntW'(1)) == loaded_q;
            mask_d[sel_res.idx] = 1'b1;
            done_d              = done_q + CntW'(1);
            t_d                 = comp;
          end else begin
            // nothing has arrived: jump to the earliest pending arrival
            t_d = TimeW'(sel_res.next_arr);
          end
        end
      end
      StOut: begin
        if (out_acc) begin
          ridx_d = '0;
          if (res_q.last_result) begin
            loaded_d = '0;
            done_d   = '0;
            mask_d   = '0;
            t_d      = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      loaded_q <= '0;
      done_q   <= '0;
      ridx_q   <= '0;
      mask_q   <= '0;
      t_q      <= '0;
      pend_q   <= 1'b0;
      pidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      done_q   <= done_d;
      ridx_q   <= ridx_d;
      mask_q   <= mask_d;
      t_q      <= t_d;
      pend_q   <= pend_d;
      pidx_q   <= pidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// File: rtl/core/pjs_checker.sv
module pjs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          in_last_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input pjs_pkg::res_t out_data_i
);
  import pjs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("job port ready while a result is pending");

  a_last_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("job port still ready after last job");

  a_times_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.turnaround <= out_data_i.completion) &&
                    (TimeW'(out_data_i.waiting) <= out_data_i.turnaround))
    else $error("result times out of order");

endmodule

bind priority_job_scheduler pjs_checker u_pjs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (job_i.valid),
  .in_ready_i  (job_i.ready),
  .in_last_i   (job_i.data.last_job),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
